FILE: rtl/rv32_pkg.sv
package rv32_pkg;

  // Operation codes, in the order of the instruction set listing.
  typedef enum logic [5:0] {
    OP_LUI = 6'd0, OP_AUIPC = 6'd1, OP_JAL = 6'd2, OP_JALR = 6'd3,
    OP_BEQ = 6'd4, OP_BNE = 6'd5, OP_BLT = 6'd6, OP_BGE = 6'd7,
    OP_BLTU = 6'd8, OP_BGEU = 6'd9, OP_LB = 6'd10, OP_LH = 6'd11,
    OP_LW = 6'd12, OP_LBU = 6'd13, OP_LHU = 6'd14, OP_SB = 6'd15,
    OP_SH = 6'd16, OP_SW = 6'd17, OP_ADDI = 6'd18, OP_SLTI = 6'd19,
    OP_SLTIU = 6'd20, OP_XORI = 6'd21, OP_ORI = 6'd22, OP_ANDI = 6'd23,
    OP_SLLI = 6'd24, OP_SRLI = 6'd25, OP_SRAI = 6'd26, OP_ADD = 6'd27,
    OP_SUB = 6'd28, OP_SLL = 6'd29, OP_SLT = 6'd30, OP_SLTU = 6'd31,
    OP_XOR = 6'd32, OP_SRL = 6'd33, OP_SRA = 6'd34, OP_OR = 6'd35,
    OP_AND = 6'd36, OP_MUL = 6'd37, OP_MULH = 6'd38, OP_MULHSU = 6'd39,
    OP_MULHU = 6'd40, OP_DIV = 6'd41, OP_DIVU = 6'd42, OP_REM = 6'd43,
    OP_REMU = 6'd44
  } op_e;

  localparam logic [31:0] PcStep   = 32'd4;
  localparam logic [31:0] JalrMask = 32'hFFFF_FFFE;
  localparam int unsigned XLen     = 32;

  // Request to the multiply/divide unit.
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic        a_signed;
    logic        b_signed;
    logic        want_high;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } md_rsp_t;

endpackage

FILE: rtl/rv32_if.sv
interface rv32_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  func;
  logic [4:0]  dest_reg;
  logic [4:0]  src1_reg;
  logic [4:0]  src2_reg;
  logic [31:0] immediate;
  modport source (output valid, func, dest_reg, src1_reg, src2_reg, immediate, input ready);
  modport sink (input valid, func, dest_reg, src1_reg, src2_reg, immediate, output ready);
endinterface

interface rv32_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        branch_taken;
  logic        wb_valid;
  logic [4:0]  wb_reg;
  logic [31:0] wb_value;
  modport source (output valid, next_pc, branch_taken, wb_valid, wb_reg, wb_value,
                  input ready);
  modport sink (input valid, next_pc, branch_taken, wb_valid, wb_reg, wb_value,
                output ready);
endinterface

FILE: rtl/rv32im_execute_unit.sv
// Channel   Dir  Fields
// in_req    in   func, dest_reg, src1_reg, src2_reg, immediate
// out_rsp   out  next_pc, branch_taken, wb_valid, wb_reg, wb_value
//
// Simple operations step through register read, operand capture, memory read and execute;
// multiply and divide then wait on the bit-serial shared adder in the multiply/divide unit.
// After reset a clearing pass zeroes the register file and data memory; no request is
// accepted meanwhile.
// One request is in flight at a time; a stalled result holds the unit.
module rv32im_execute_unit import rv32_pkg::*; #(
  parameter int unsigned DATA_WORDS = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  rv32_in_if.sink   in_req,
  rv32_out_if.source out_rsp
);

  localparam int unsigned AW = $clog2(DATA_WORDS);
  localparam int unsigned CW = (AW > 5) ? AW : 5;
  localparam logic [CW:0] ClrLen = (DATA_WORDS > 32) ? (CW+1)'(DATA_WORDS) : (CW+1)'(32);

  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_EXE = 3'd3,
                         S_MD = 3'd4, S_OUT = 3'd5, S_OP = 3'd6, S_MEM = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [CW:0] clr_q;
  logic [31:0] pc_q;
  logic [5:0]  func_q;
  logic [4:0]  rd_q, rs1_q, rs2_q;
  logic [31:0] imm_q;
  logic [31:0] a_q, b_q, word_q;
  logic [31:0] rf [32];
  logic [31:0] mem [DATA_WORDS];
  logic [31:0] rf_a, rf_b;

  // Output register.
  logic [31:0] npc_q, val_q;
  logic        tk_q, wb_q;
  logic [4:0]  wbr_q;

  md_req_t md_req;
  md_rsp_t md_rsp;

  logic [31:0] addr;
  logic [AW-1:0] widx;
  logic [4:0]  bsh, hsh;
  logic [7:0]  byt;
  logic [15:0] half;
  logic        is_md, lt_s, lt_u, cond;
  logic [31:0] npc_c, val_c, store_w;
  logic        wb_c, tk_c, st_c;
  logic [31:0] sh_src;
  logic [4:0]  sh_amt;

  assign in_req.ready = (state_q == S_IDLE);
  assign out_rsp.valid = (state_q == S_OUT);
  assign out_rsp.next_pc = npc_q;
  assign out_rsp.branch_taken = tk_q;
  assign out_rsp.wb_valid = wb_q;
  assign out_rsp.wb_reg = wbr_q;
  assign out_rsp.wb_value = val_q;

  assign is_md = (func_q >= OP_MUL) && (func_q <= OP_REMU);

  // Address of a load or store, wrapped modulo the memory.
  always_comb begin
    addr = a_q + imm_q;
    widx = addr[AW+1:2];
    bsh = {addr[1:0], 3'b000};
    hsh = {addr[1], 4'b0000};
    byt = 8'(word_q >> bsh);
    half = 16'(word_q >> hsh);
    lt_u = a_q < b_q;
    lt_s = $signed(a_q) < $signed(b_q);
  end

  // Execute everything but multiply and divide.
  always_comb begin
    npc_c = pc_q + PcStep; tk_c = 1'b0; wb_c = 1'b1; val_c = 32'd0; st_c = 1'b0;
    store_w = word_q; cond = 1'b0;
    sh_src = a_q; sh_amt = b_q[4:0];
    if (func_q >= OP_SLLI && func_q <= OP_SRAI) sh_amt = imm_q[4:0];
    case (func_q)
      OP_LUI:   val_c = imm_q;
      OP_AUIPC: val_c = pc_q + imm_q;
      OP_JAL:   begin val_c = pc_q + PcStep; npc_c = pc_q + imm_q; tk_c = 1'b1; end
      OP_JALR:  begin val_c = pc_q + PcStep; npc_c = (a_q + imm_q) & JalrMask; tk_c = 1'b1; end
      OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
        wb_c = 1'b0;
        case (func_q)
          OP_BEQ:  cond = a_q == b_q;
          OP_BNE:  cond = a_q != b_q;
          OP_BLT:  cond = lt_s;
          OP_BGE:  cond = !lt_s;
          OP_BLTU: cond = lt_u;
          default: cond = !lt_u;
        endcase
        if (cond) begin npc_c = pc_q + imm_q; tk_c = 1'b1; end
      end
      OP_LB:  val_c = {{24{byt[7]}}, byt};
      OP_LH:  val_c = {{16{half[15]}}, half};
      OP_LW:  val_c = word_q;
      OP_LBU: val_c = {24'd0, byt};
      OP_LHU: val_c = {16'd0, half};
      OP_SB: begin
        wb_c = 1'b0; st_c = 1'b1;
        store_w = (word_q & ~(32'hFF << bsh)) | ({24'd0, b_q[7:0]} << bsh);
      end
      OP_SH: begin
        wb_c = 1'b0; st_c = 1'b1;
        store_w = (word_q & ~(32'hFFFF << hsh)) | ({16'd0, b_q[15:0]} << hsh);
      end
      OP_SW:    begin wb_c = 1'b0; st_c = 1'b1; store_w = b_q; end
      OP_ADDI:  val_c = a_q + imm_q;
      OP_SLTI:  val_c = {31'd0, $signed(a_q) < $signed(imm_q)};
      OP_SLTIU: val_c = {31'd0, a_q < imm_q};
      OP_XORI:  val_c = a_q ^ imm_q;
      OP_ORI:   val_c = a_q | imm_q;
      OP_ANDI:  val_c = a_q & imm_q;
      OP_SLLI, OP_SLL: val_c = sh_src << sh_amt;
      OP_SRLI, OP_SRL: val_c = sh_src >> sh_amt;
      OP_SRAI, OP_SRA: val_c = 32'($signed(sh_src) >>> sh_amt);
      OP_ADD:  val_c = a_q + b_q;
      OP_SUB:  val_c = a_q - b_q;
      OP_SLT:  val_c = {31'd0, lt_s};
      OP_SLTU: val_c = {31'd0, lt_u};
      OP_XOR:  val_c = a_q ^ b_q;
      OP_OR:   val_c = a_q | b_q;
      OP_AND:  val_c = a_q & b_q;
      default: wb_c = is_md;
    endcase
  end

  // Request to the shared multiply/divide unit.
  always_comb begin
    md_req.start = (state_q == S_EXE) && is_md;
    md_req.is_div = func_q >= OP_DIV;
    md_req.a_signed = (func_q == OP_MULH) || (func_q == OP_MULHSU) ||
                      (func_q == OP_DIV) || (func_q == OP_REM);
    md_req.b_signed = (func_q == OP_MULH) || (func_q == OP_DIV) || (func_q == OP_REM);
    md_req.want_high = (func_q == OP_MULH) || (func_q == OP_MULHSU) ||
                       (func_q == OP_MULHU) || (func_q == OP_REM) || (func_q == OP_REMU);
    md_req.a = a_q;
    md_req.b = b_q;
  end

  rv32_muldiv u_md (.clk_i, .rst_ni, .req_i(md_req), .rsp_o(md_rsp));

  // Sequencer. Register read, operand capture and memory read each have a state of their
  // own before execute.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (clr_q == ClrLen - 1'b1) state_d = S_IDLE;
      S_IDLE: if (in_req.valid) state_d = S_RD;
      S_RD:   state_d = S_OP;
      S_OP:   state_d = S_MEM;
      S_MEM:  state_d = S_EXE;
      S_EXE:  state_d = is_md ? S_MD : S_OUT;
      S_MD:   if (md_rsp.done) state_d = S_OUT;
      S_OUT:  if (out_rsp.ready) state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      pc_q <= 32'd0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (state_q == S_EXE && !is_md) pc_q <= npc_c;
      if (state_q == S_MD && md_rsp.done) pc_q <= pc_q + PcStep;
    end
  end

  // Register file: cleared by the sweep, written at result time.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) begin
      if (clr_q < (CW+1)'(32)) rf[clr_q[4:0]] <= 32'd0;
    end else if (state_q == S_EXE && !is_md && wb_c && rd_q != 5'd0) begin
      rf[rd_q] <= val_c;
    end else if (state_q == S_MD && md_rsp.done && rd_q != 5'd0) begin
      rf[rd_q] <= md_rsp.result;
    end
    rf_a <= rf[rs1_q];
    rf_b <= rf[rs2_q];
  end

  // Data memory: read once the operands have settled, written in execute.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) begin
      if (clr_q < ClrLen && clr_q < (CW+1)'(DATA_WORDS)) mem[clr_q[AW-1:0]] <= 32'd0;
    end else if (state_q == S_EXE && st_c) begin
      mem[widx] <= store_w;
    end
    word_q <= mem[widx];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_req.valid && in_req.ready) begin
      func_q <= in_req.func; rd_q <= in_req.dest_reg;
      rs1_q <= in_req.src1_reg; rs2_q <= in_req.src2_reg; imm_q <= in_req.immediate;
    end
    a_q <= (rs1_q == 5'd0) ? 32'd0 : rf_a;
    b_q <= (rs2_q == 5'd0) ? 32'd0 : rf_b;
    if (state_q == S_EXE && !is_md) begin
      npc_q <= npc_c; tk_q <= tk_c;
      wb_q <= wb_c && rd_q != 5'd0;
      wbr_q <= (wb_c && rd_q != 5'd0) ? rd_q : 5'd0;
      val_q <= (wb_c && rd_q != 5'd0) ? val_c : 32'd0;
    end else if (state_q == S_MD && md_rsp.done) begin
      npc_q <= pc_q + PcStep; tk_q <= 1'b0;
      wb_q <= rd_q != 5'd0;
      wbr_q <= rd_q;
      val_q <= (rd_q != 5'd0) ? md_rsp.result : 32'd0;
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req.ready |-> !out_rsp.valid) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_rsp.valid && !out_rsp.ready) |=> $stable(out_rsp.next_pc))
    else $error("result changed under stall");
  a_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_rsp.valid |-> (out_rsp.wb_valid || out_rsp.wb_reg == 5'd0))
    else $error("register number without write-back");
`endif

endmodule

FILE: rtl/rv32_muldiv.sv
module rv32_muldiv import rv32_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  // One shared adder, a bit a cycle: shift-add multiply or restoring divide.
  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] acc_q, acc_d;
  logic [32:0] opb_q, opb_d;
  logic [31:0] ra_q, ra_d;
  logic        div_q, div_d, neg_q, neg_d, high_q, high_d, remneg_q, remneg_d;
  logic        byz_q, byz_d;
  logic [31:0] amag, bmag;
  logic        asgn, bsgn;
  logic [33:0] sum;
  logic [31:0] res;
  logic [63:0] prod;

  always_comb begin
    asgn = req_i.a_signed & req_i.a[31];
    bsgn = req_i.b_signed & req_i.b[31];
    amag = asgn ? (32'd0 - req_i.a) : req_i.a;
    bmag = bsgn ? (32'd0 - req_i.b) : req_i.b;
  end

  // Shared adder: add for multiply, trial subtract for divide.
  always_comb begin
    if (div_q) begin
      sum = {1'b0, acc_q[63:31]} - {1'b0, opb_q};
    end else begin
      sum = {1'b0, acc_q[63:32]} + {1'b0, opb_q} ;
    end
  end

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; acc_d = acc_q; opb_d = opb_q;
    div_d = div_q; neg_d = neg_q; high_d = high_q; remneg_d = remneg_q;
    byz_d = byz_q; ra_d = ra_q;
    if (!busy_q && req_i.start) begin
      busy_d = 1'b1;
      cnt_d = 6'd0;
      div_d = req_i.is_div;
      high_d = req_i.want_high;
      ra_d = req_i.a;
      byz_d = (req_i.b == 32'd0);
      if (req_i.is_div) begin
        acc_d = {32'd0, amag};
        opb_d = {1'b0, bmag};
        neg_d = asgn ^ bsgn;
        remneg_d = asgn;
      end else begin
        acc_d = {32'd0, amag};
        opb_d = {1'b0, bmag};
        neg_d = asgn ^ bsgn;
        remneg_d = 1'b0;
      end
    end else if (busy_q && cnt_q != 6'd32) begin
      cnt_d = cnt_q + 6'd1;
      if (div_q) begin
        // acc = {rem[31:0], quo[31:0]}; shift then trial subtract
        if (!sum[33]) begin
          acc_d = {sum[31:0], acc_q[30:0], 1'b1};
        end else begin
          acc_d = {acc_q[62:0], 1'b0};
        end
      end else begin
        if (acc_q[0]) begin
          acc_d = {sum[32:0], acc_q[31:1]};
        end else begin
          acc_d = {1'b0, acc_q[63:1]};
        end
      end
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    prod = neg_q ? (64'd0 - acc_q) : acc_q;
    if (!div_q) begin
      res = high_q ? prod[63:32] : prod[31:0];
    end else if (byz_q) begin
      res = high_q ? ra_q : 32'hFFFF_FFFF;
    end else if (high_q) begin
      res = remneg_q ? (32'd0 - acc_q[63:32]) : acc_q[63:32];
    end else begin
      res = neg_q ? (32'd0 - acc_q[31:0]) : acc_q[31:0];
    end
  end

  assign rsp_o.done = busy_q && (cnt_q == 6'd32);
  assign rsp_o.result = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 6'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; opb_q <= opb_d; div_q <= div_d; neg_q <= neg_d;
    high_q <= high_d; remneg_q <= remneg_d; byz_q <= byz_d; ra_q <= ra_d;
  end

endmodule
